### rtl/rpsd_pkg.sv
// Shared types and constants for the RLE pixel stream decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rpsd_pkg;

  // Header classification state of the byte parser
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_RUN     = 2'd1,
    PH_LITERAL = 2'd2
  } phase_t;

  // Pixel byte order inside a packet
  localparam logic [1:0] POS_BLUE  = 2'd0;
  localparam logic [1:0] POS_GREEN = 2'd1;
  localparam logic [1:0] POS_RED   = 2'd2;

  // Register map (word addresses)
  localparam logic [1:0] REG_END_MARKER = 2'd0;

  // Token queue between parser and output stage
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One decoded result
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [6:0] repeat_count;
    logic       stream_end;
  } token_t;

endpackage

### rtl/rpsd_front.sv
// Byte parser: tracks packet headers and pixel bytes, emits decoded tokens.
// Depends on rpsd_pkg.
`timescale 1ns / 1ps

module rpsd_front import rpsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic [7:0] end_marker,
  output logic       push,
  output token_t     tok
);

  phase_t     phase, phase_next;
  logic [1:0] byte_position, byte_position_next;
  logic [7:0] blue_hold, blue_hold_next;
  logic [7:0] green_hold, green_hold_next;
  logic [6:0] literals_left, literals_left_next;
  logic [6:0] run_length, run_length_next;
  logic [6:0] literals_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      byte_position <= POS_BLUE;
      literals_left <= '0;
      run_length    <= '0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      literals_left <= literals_left_next;
      run_length    <= run_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blue_hold  <= '0;
      green_hold <= '0;
    end else begin
      blue_hold  <= blue_hold_next;
      green_hold <= green_hold_next;
    end
  end

  assign literals_dec = literals_left - 7'd1;

  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    blue_hold_next     = blue_hold;
    green_hold_next    = green_hold;
    literals_left_next = literals_left;
    run_length_next    = run_length;
    push               = 1'b0;
    tok                = '{blue: blue_hold, green: green_hold, red: data_byte,
                           repeat_count: 7'd1, stream_end: 1'b0};
    if (accept) begin
      case (phase)
        PH_RUN, PH_LITERAL: begin
          if (byte_position == POS_BLUE) begin
            blue_hold_next     = data_byte;
            byte_position_next = POS_GREEN;
          end else if (byte_position == POS_GREEN) begin
            green_hold_next    = data_byte;
            byte_position_next = POS_RED;
          end else begin
            // red byte completes the pixel
            byte_position_next = POS_BLUE;
            if (phase == PH_RUN) begin
              phase_next       = PH_HEADER;
              push             = (run_length != 7'd0);
              tok.repeat_count = run_length;
            end else begin
              literals_left_next = literals_dec;
              push               = 1'b1;
              if (literals_dec == 7'd0) begin
                phase_next = PH_HEADER;
              end
            end
          end
        end
        default: begin
          byte_position_next = POS_BLUE;
          phase_next         = PH_HEADER;
          if (data_byte == end_marker) begin
            push = 1'b1;
            tok  = '{blue: 8'd0, green: 8'd0, red: 8'd0,
                     repeat_count: 7'd0, stream_end: 1'b1};
          end else if (data_byte[7]) begin
            run_length_next = data_byte[6:0];
            phase_next      = PH_RUN;
          end else if (data_byte != 8'd0) begin
            literals_left_next = data_byte[6:0];
            phase_next         = PH_LITERAL;
          end
        end
      endcase
    end
  end

endmodule

### rtl/rpsd_queue.sv
// Two-entry token queue decoupling the parser from the output stage.
// Depends on rpsd_pkg.
`timescale 1ns / 1ps

module rpsd_queue import rpsd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  token_t push_tok,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output token_t head
);

  token_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full      = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && full) |-> pop)
    else $error("token pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("token popped from empty queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && !full) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow push");
`endif

endmodule

### rtl/rpsd_back.sv
// Output stage: registers the queue head and drives the result channel.
// Depends on rpsd_pkg.
`timescale 1ns / 1ps

module rpsd_back import rpsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_not_empty,
  input  token_t     q_head,
  output logic       pop,
  output logic       pixel_valid,
  input  logic       pixel_ready,
  output logic [7:0] blue,
  output logic [7:0] green,
  output logic [7:0] red,
  output logic [6:0] repeat_count,
  output logic       stream_end
);

  token_t held;

  // load a new token when the output register is empty or being drained
  assign pop = q_not_empty && (!pixel_valid || pixel_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!pixel_valid || pixel_ready) begin
      pixel_valid <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      held <= q_head;
    end
  end

  assign blue         = held.blue;
  assign green        = held.green;
  assign red          = held.red;
  assign repeat_count = held.repeat_count;
  assign stream_end   = held.stream_end;

endmodule

### rtl/rle_pixel_stream_decoder.sv
// Top level of the RLE pixel stream decoder: register port, parser, queue, output.
// Depends on rpsd_pkg, rpsd_front, rpsd_queue, rpsd_back.
`timescale 1ns / 1ps

// Decodes a run-length coded stream of 24-bit pixels (blue, green, red), one
// byte per cycle while the queue is not full. A header above 127 yields one pixel with
// repeat_count = header - 128 (none if zero); a header 1..127 yields that many
// pixels with repeat_count 1; the header equal to end_marker yields a transfer
// with stream_end set and all other fields zero, after which a new header is
// expected. The parser writes the token into a two-entry queue at the edge
// that accepts the completing byte, and the output register loads it from the
// queue when empty or being drained, raising pixel_valid. The queue lets the
// input keep accepting while an output transfer waits, until two tokens are
// queued. end_marker sits at address 0; the user must write it only while
// idle, as the block itself does not enforce this.
module rle_pixel_stream_decoder import rpsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  output logic        pixel_valid,
  input  logic        pixel_ready,
  output logic [7:0]  blue,
  output logic [7:0]  green,
  output logic [7:0]  red,
  output logic [6:0]  repeat_count,
  output logic        stream_end
);

  logic [7:0] end_marker;
  logic       accept;
  logic       push;
  token_t     push_tok;
  logic       pop;
  logic       q_full;
  logic       q_not_empty;
  token_t     q_head;

  assign pready = 1'b1;

  // one register; byte offsets within the word all select it
  always_ff @(posedge clk) begin
    if (rst) begin
      end_marker <= '0;
    end else if (psel && penable && pwrite) begin
      end_marker <= pwdata[7:0];
    end
  end

  assign prdata = (paddr == REG_END_MARKER) ? {24'd0, end_marker} : {24'd0, end_marker};

  assign data_ready = !q_full;
  assign accept     = data_valid && data_ready;

  rpsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .end_marker (end_marker),
    .push       (push),
    .tok        (push_tok)
  );

  rpsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_tok  (push_tok),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  rpsd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .pop          (pop),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .blue         (blue),
    .green        (green),
    .red          (red),
    .repeat_count (repeat_count),
    .stream_end   (stream_end)
  );

endmodule

### tb/sv/tb.sv
// Self-checking bench for rle_pixel_stream_decoder: a table of directed bytes,
// then random packet streams under several end markers and idling modes.
// Depends on rpsd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb;
  import rpsd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES = 285;
  localparam logic [1:0] MARKER_ADDR = 2'(int'(REG_END_MARKER) * 4);

  typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_TOKEN, ROW_MARKER} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] value;
    token_t     want;
  } stim_row_t;

  localparam token_t NO_TOK = '0;
  localparam token_t END_TOK = {8'h00, 8'h00, 8'h00, 7'd0, 1'b1};
  localparam token_t MAX_RUN_TOK = {8'hFF, 8'hFF, 8'hFF, 7'd127, 1'b0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        data_valid = 1'b0;
  logic        data_ready;
  logic [7:0]  data_byte = '0;
  logic        pixel_valid;
  logic        pixel_ready = 1'b0;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic [6:0]  repeat_count;
  logic        stream_end;

  rle_pixel_stream_decoder dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .data_valid(data_valid), .data_ready(data_ready), .data_byte(data_byte),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
    .blue(blue), .green(green), .red(red),
    .repeat_count(repeat_count), .stream_end(stream_end)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // decoder state as predicted
  phase_t     ph = PH_HEADER;
  logic [1:0] pos = POS_BLUE;
  logic [7:0] hold_blue = '0;
  logic [7:0] hold_green = '0;
  logic [6:0] lits_left = '0;
  logic [6:0] run_len = '0;
  logic [7:0] marker = '0;

  token_t    pending_pixels[$];
  stim_row_t byte_plan[$];

  int send_pct = 0;
  int recv_pct = 0;
  int mismatches = 0;
  int bytes_driven = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int ends_seen = 0;
  int quiet_cycles = 0;

  // Directed stream; starts with the reset end marker of zero.
  stim_row_t dir_rows [0:23] = '{
    {ROW_TOKEN,   8'h00, END_TOK},     // marker zero wins over a zero literal count
    {ROW_QUIET,   8'hFF, NO_TOK},      // longest run
    {ROW_QUIET,   8'hFF, NO_TOK},
    {ROW_QUIET,   8'hFF, NO_TOK},
    {ROW_TOKEN,   8'hFF, MAX_RUN_TOK},
    {ROW_PREDICT, 8'h81, NO_TOK},
    {ROW_PREDICT, 8'h00, NO_TOK},
    {ROW_PREDICT, 8'h00, NO_TOK},
    {ROW_PREDICT, 8'h00, NO_TOK},
    {ROW_PREDICT, 8'h80, NO_TOK},      // zero-length run eats its pixel silently
    {ROW_PREDICT, 8'h12, NO_TOK},
    {ROW_PREDICT, 8'h34, NO_TOK},
    {ROW_PREDICT, 8'h56, NO_TOK},
    {ROW_PREDICT, 8'h01, NO_TOK},      // marker value inside pixel data
    {ROW_PREDICT, 8'h00, NO_TOK},
    {ROW_PREDICT, 8'h5A, NO_TOK},
    {ROW_PREDICT, 8'hA5, NO_TOK},
    {ROW_MARKER,  8'h80, NO_TOK},
    {ROW_QUIET,   8'h00, NO_TOK},      // zero literal count, no longer the marker
    {ROW_TOKEN,   8'h80, END_TOK},
    {ROW_PREDICT, 8'h01, NO_TOK},
    {ROW_PREDICT, 8'h80, NO_TOK},
    {ROW_PREDICT, 8'h80, NO_TOK},
    {ROW_PREDICT, 8'h80, NO_TOK}
  };

  function automatic bit decode_byte(input logic [7:0] v, output token_t t);
    t = NO_TOK;
    if (ph == PH_RUN || ph == PH_LITERAL) begin
      if (pos == POS_BLUE) begin
        hold_blue = v;
        pos = POS_GREEN;
        return 1'b0;
      end
      if (pos == POS_GREEN) begin
        hold_green = v;
        pos = POS_RED;
        return 1'b0;
      end
      pos = POS_BLUE;
      t.blue = hold_blue;
      t.green = hold_green;
      t.red = v;
      if (ph == PH_RUN) begin
        ph = PH_HEADER;
        t.repeat_count = run_len;
        return run_len != 7'd0;
      end
      lits_left = lits_left - 7'd1;
      if (lits_left == 7'd0) ph = PH_HEADER;
      t.repeat_count = 7'd1;
      return 1'b1;
    end
    ph = PH_HEADER;
    pos = POS_BLUE;
    if (v == marker) begin
      t.stream_end = 1'b1;
      return 1'b1;
    end
    if (v[7]) begin
      run_len = v[6:0];
      ph = PH_RUN;
    end else if (v != 8'h00) begin
      lits_left = v[6:0];
      ph = PH_LITERAL;
    end
    return 1'b0;
  endfunction

  function automatic void report_mismatch(input string what, input token_t want,
                                          input token_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected b=%02h g=%02h r=%02h rep=%0d end=%0b",
               $time, what, want.blue, want.green, want.red, want.repeat_count,
               want.stream_end);
      $display("    got b=%02h g=%02h r=%02h rep=%0d end=%0b",
               got.blue, got.green, got.red, got.repeat_count, got.stream_end);
    end
  endfunction

  always @(negedge clk) pixel_ready <= ($urandom_range(99) >= recv_pct);

  always @(posedge clk) begin : monitor
    stim_row_t row;
    token_t pred, got, want;
    bit fires;
    if (!rst) begin
      if (data_valid && data_ready) begin
        row = (byte_plan.size() != 0) ? byte_plan.pop_front() : stim_row_t'(0);
        fires = decode_byte(data_byte, pred);
        bytes_taken++;
        case (row.kind)
          ROW_TOKEN: pending_pixels = {pending_pixels, row.want};
          ROW_QUIET: ;
          default: if (fires) pending_pixels = {pending_pixels, pred};
        endcase
      end
      if (pixel_valid && pixel_ready) begin
        got = {blue, green, red, repeat_count, stream_end};
        results_seen++;
        if (stream_end) ends_seen++;
        if (pending_pixels.size() == 0) begin
          report_mismatch("unexpected transfer", NO_TOK, got);
        end else begin
          want = pending_pixels.pop_front();
          if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red ||
              got.repeat_count !== want.repeat_count || got.stream_end !== want.stream_end)
            report_mismatch("pixel mismatch", want, got);
        end
      end
      if ((data_valid && data_ready) || (pixel_valid && pixel_ready) ||
          (psel && penable && pready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d pixels outstanding",
                 QUIET_LIMIT, pending_pixels.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_byte(input stim_row_t row);
    if (send_pct > 0 && $urandom_range(99) < send_pct) begin
      data_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_pct);
    end
    byte_plan = {byte_plan, row};
    data_valid <= 1'b1;
    data_byte <= row.value;
    bytes_driven++;
    do @(posedge clk); while (!data_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    data_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_marker(input logic [7:0] value);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MARKER_ADDR;
    pwdata <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    marker = value;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'd0, value}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: end_marker readback: expected %08h, got %08h",
                 $time, {24'd0, value}, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] pixel_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return marker;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed packets; some stray bytes break sequences mid-packet.
  task automatic random_stream(input int n_bytes);
    int target, cnt, pick;
    target = bytes_driven + n_bytes;
    while (bytes_driven < target) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        push_byte({ROW_PREDICT, (pick < 3) ? 8'h80 : 8'($urandom_range(255, 129)), NO_TOK});
        repeat (3) push_byte({ROW_PREDICT, pixel_byte(), NO_TOK});
      end else if (pick < 80) begin
        cnt = ($urandom_range(99) == 0) ? $urandom_range(127, 32) : $urandom_range(6, 1);
        push_byte({ROW_PREDICT, 8'(cnt), NO_TOK});
        repeat (3 * cnt) push_byte({ROW_PREDICT, pixel_byte(), NO_TOK});
      end else if (pick < 85) begin
        push_byte({ROW_PREDICT, 8'h00, NO_TOK});
      end else if (pick < 92) begin
        push_byte({ROW_PREDICT, marker, NO_TOK});
      end else begin
        repeat ($urandom_range(3, 1))
          push_byte({ROW_PREDICT, 8'($urandom_range(255)), NO_TOK});
      end
    end
  endtask

  initial begin : stimulus
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_MARKER)
        write_marker(dir_rows[i].value);
      else
        push_byte(dir_rows[i]);
    end

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: write_marker(8'hFF);
        1: write_marker(8'h7F);
        2: write_marker(8'h00);
        3: write_marker(8'($urandom_range(255)));
        default: write_marker(8'h80);
      endcase
      send_pct = (p == 1) ? 58 : (p == 3) ? 28 : 0;
      recv_pct = (p == 2) ? 58 : (p == 3) ? 28 : 0;
      random_stream(PHASE_BYTES);
    end

    send_pct = 0;
    recv_pct = 0;
    wait_idle();
    $display("Fed %0d stream bytes; %0d pixel transfers came back, %0d of them stream ends.",
             bytes_taken, results_seen, ends_seen);
    $display("Covered six end marker settings and four idling mixes, %0d mismatches.",
             mismatches);
    if (mismatches == 0 && pending_pixels.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
